### sv/nsp_pkg.sv
// ----------------------------------------------------------------------------
// nsp_pkg
// Shared constants for the numeric string parser: register indexes, radix and
// status codes, character codes and default widths.
// ----------------------------------------------------------------------------
package nsp_pkg;

  localparam int VALUE_WIDTH_DEF = 64;

  localparam int CFG_INDEX_WIDTH = 2;
  localparam int CFG_DATA_WIDTH  = 4;

  // Configuration register indexes
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_BASE_MODE  = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_SIZE_BYTES = 2'd1;

  // Radix codes (also the base_mode encoding; zero means any)
  localparam logic [1:0] RAD_ANY = 2'd0;
  localparam logic [1:0] RAD_BIN = 2'd1;
  localparam logic [1:0] RAD_DEC = 2'd2;
  localparam logic [1:0] RAD_HEX = 2'd3;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_RANGE   = 2'd2;

  localparam logic [3:0] SIZE_BYTES_RST = 4'd8;

  // Character codes
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_B  = 8'h42;
  localparam logic [7:0] CH_UP_D  = 8'h44;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_UP_Z  = 8'h5A;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_B  = 8'h62;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_LO_Z  = 8'h7A;
  localparam logic [7:0] DIGIT_NONE = 8'hFF;

  typedef logic [1:0] status_t;

endpackage

### sv/numeric_string_parser_top.sv
// ----------------------------------------------------------------------------
// numeric_string_parser_top
// Parses an unsigned number from a character stream, one character per
// transaction, and emits value and status when a NUL character arrives.
// ----------------------------------------------------------------------------
// Takes one character per cycle unless stalled: each character goes through an
// input register and then one shift-add-and-compare step on the accumulator,
// which sets the rate. A NUL character moves on from the input register to
// the output register. Input stalls only while a result waits in the output
// register and a NUL is ready to replace it. The form is optional whitespace,
// an optional '=', '+' or '-' (minus has no effect), an optional "0b", "0d" or
// "0x" prefix, digits and optional trailing whitespace. base_mode selects the
// required radix (0 takes it from the prefix, decimal if none); size_bytes
// limits the value. The first error sticks until the NUL; an error result
// carries value zero. Configuration may be written only while idle.
module numeric_string_parser_top #(
  parameter int VALUE_WIDTH = nsp_pkg::VALUE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // character channel
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         char_in,
  // result channel
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [VALUE_WIDTH-1:0]             value,
  output logic [1:0]                         status,
  // configuration channel
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [nsp_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  logic [nsp_pkg::CFG_DATA_WIDTH-1:0]  cfg_data
);

  localparam int EXT_WIDTH = VALUE_WIDTH + 5;

  localparam logic [2:0] PH_LEAD   = 3'd0;
  localparam logic [2:0] PH_SIGN   = 3'd1;
  localparam logic [2:0] PH_ZERO   = 3'd2;
  localparam logic [2:0] PH_LETTER = 3'd3;
  localparam logic [2:0] PH_DIGITS = 3'd4;
  localparam logic [2:0] PH_TRAIL  = 3'd5;

  function automatic logic [7:0] digit_of(input logic [7:0] c);
    logic [7:0] d;
    d = nsp_pkg::DIGIT_NONE;
    if (c >= nsp_pkg::CH_ZERO && c <= nsp_pkg::CH_NINE) begin
      d = c - nsp_pkg::CH_ZERO;
    end else if (c >= nsp_pkg::CH_LO_A && c <= nsp_pkg::CH_LO_Z) begin
      d = c - nsp_pkg::CH_LO_A + 8'd10;
    end else if (c >= nsp_pkg::CH_UP_A && c <= nsp_pkg::CH_UP_Z) begin
      d = c - nsp_pkg::CH_UP_A + 8'd10;
    end
    return d;
  endfunction

  // Configuration registers
  logic [1:0] base_mode;
  logic [3:0] size_bytes;

  // Input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_hold;
  logic       s1_fire;
  logic       s1_nul;

  // Parse state
  logic [2:0]             phase, phase_next;
  logic [1:0]             radix, radix_next;
  logic [VALUE_WIDTH-1:0] acc, acc_next;
  nsp_pkg::status_t       err, err_next;

  // Per-character decode
  logic                   is_sp, is_sign, is_zero;
  logic [1:0]             prefix_code, dflt_radix, use_radix;
  logic [7:0]             dig;
  logic [4:0]             radix_val;
  logic                   do_digits;
  logic [EXT_WIDTH-1:0]   acc_ext, prod, sum;
  logic                   carry, over_limit;
  logic [6:0]             limit_bits;
  logic [VALUE_WIDTH-1:0] limit_mask;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_mode  <= nsp_pkg::RAD_ANY;
      size_bytes <= nsp_pkg::SIZE_BYTES_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        nsp_pkg::REG_BASE_MODE:  base_mode  <= cfg_data[1:0];
        nsp_pkg::REG_SIZE_BYTES: size_bytes <= cfg_data;
        default: ;
      endcase
    end
  end

  // A NUL in the input register needs a free output slot
  assign s1_nul   = (s1_char == nsp_pkg::CH_NUL);
  assign s1_hold  = s1_valid && s1_nul && out_valid && out_stall;
  assign s1_fire  = s1_valid && !s1_hold;
  assign in_stall = s1_hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_char <= char_in;
    end
  end

  // Character classes
  assign is_sp   = (s1_char == nsp_pkg::CH_SPACE) ||
                   (s1_char >= nsp_pkg::CH_TAB && s1_char <= nsp_pkg::CH_CR);
  assign is_sign = (s1_char == nsp_pkg::CH_EQUAL) || (s1_char == nsp_pkg::CH_PLUS) ||
                   (s1_char == nsp_pkg::CH_MINUS);
  assign is_zero = (s1_char == nsp_pkg::CH_ZERO);
  assign dig     = digit_of(s1_char);

  always_comb begin
    case (s1_char)
      nsp_pkg::CH_LO_B, nsp_pkg::CH_UP_B: prefix_code = nsp_pkg::RAD_BIN;
      nsp_pkg::CH_LO_D, nsp_pkg::CH_UP_D: prefix_code = nsp_pkg::RAD_DEC;
      nsp_pkg::CH_LO_X, nsp_pkg::CH_UP_X: prefix_code = nsp_pkg::RAD_HEX;
      default:                            prefix_code = nsp_pkg::RAD_ANY;
    endcase
  end

  assign dflt_radix = (base_mode == nsp_pkg::RAD_ANY) ? nsp_pkg::RAD_DEC : base_mode;

  // Range mask: bits at or above 8*size_bytes must stay clear
  assign limit_bits = {size_bytes, 3'b000};
  always_comb begin
    for (int i = 0; i < VALUE_WIDTH; i++) begin
      limit_mask[i] = (limit_bits > 7'(i));
    end
  end

  // Phase walk; characters that end one phase fall into the next
  always_comb begin
    phase_next = phase;
    radix_next = radix;
    err_next   = err;
    use_radix  = radix;
    do_digits  = 1'b0;
    case (phase)
      PH_LEAD, PH_SIGN, PH_ZERO: begin
        if (phase == PH_LEAD && is_sp) begin
          phase_next = PH_LEAD;
        end else if (phase != PH_ZERO && is_sign) begin
          phase_next = PH_ZERO;
        end else if (is_zero) begin
          phase_next = PH_LETTER;
        end else begin
          radix_next = dflt_radix;
          use_radix  = dflt_radix;
          do_digits  = 1'b1;
        end
      end
      PH_LETTER: begin
        if (prefix_code != nsp_pkg::RAD_ANY) begin
          radix_next = prefix_code;
          phase_next = PH_DIGITS;
          if (base_mode != nsp_pkg::RAD_ANY && base_mode != prefix_code) begin
            err_next = nsp_pkg::ST_INVALID;
          end
        end else begin
          radix_next = dflt_radix;
          use_radix  = dflt_radix;
          do_digits  = 1'b1;
        end
      end
      PH_DIGITS: do_digits = 1'b1;
      PH_TRAIL: begin
        if (!is_sp) begin
          err_next = nsp_pkg::ST_INVALID;
        end
      end
      default: phase_next = PH_LEAD;
    endcase
  end

  // Shift-add for one digit
  assign acc_ext = EXT_WIDTH'(acc);
  always_comb begin
    case (use_radix)
      nsp_pkg::RAD_BIN: begin
        radix_val = 5'd2;
        prod      = acc_ext << 1;
      end
      nsp_pkg::RAD_HEX: begin
        radix_val = 5'd16;
        prod      = acc_ext << 4;
      end
      default: begin
        radix_val = 5'd10;
        prod      = (acc_ext << 3) + (acc_ext << 1);
      end
    endcase
  end

  assign sum        = prod + EXT_WIDTH'(dig[3:0]);
  assign carry      = |sum[EXT_WIDTH-1:VALUE_WIDTH];
  assign over_limit = |(sum[VALUE_WIDTH-1:0] & ~limit_mask);

  logic [2:0]       phase_fin;
  nsp_pkg::status_t err_fin;

  always_comb begin
    phase_fin = phase_next;
    err_fin   = err_next;
    acc_next  = acc;
    if (do_digits) begin
      phase_fin = PH_DIGITS;
      if (dig < {3'b000, radix_val}) begin
        if (carry) begin
          err_fin = nsp_pkg::ST_RANGE;
        end else begin
          acc_next = sum[VALUE_WIDTH-1:0];
          if (over_limit) begin
            err_fin = nsp_pkg::ST_RANGE;
          end
        end
      end else if (is_sp) begin
        phase_fin = PH_TRAIL;
      end else begin
        err_fin = nsp_pkg::ST_INVALID;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_LEAD;
      radix <= nsp_pkg::RAD_DEC;
      acc   <= '0;
      err   <= nsp_pkg::ST_OK;
    end else if (s1_fire) begin
      if (s1_nul) begin
        phase <= PH_LEAD;
        radix <= nsp_pkg::RAD_DEC;
        acc   <= '0;
        err   <= nsp_pkg::ST_OK;
      end else if (err == nsp_pkg::ST_OK) begin
        // drop everything after the first error
        phase <= phase_fin;
        radix <= radix_next;
        acc   <= acc_next;
        err   <= err_fin;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && s1_nul) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_nul) begin
      value  <= (err == nsp_pkg::ST_OK) ? acc : '0;
      status <= err;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_error_value_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != nsp_pkg::ST_OK) |-> (value == '0))
    else $error("error result carries a nonzero value");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status != 2'd3))
    else $error("undefined status code");

  a_nul_clears: assert property (@(posedge clk) disable iff (rst)
    (s1_fire && s1_nul) |=> (phase == PH_LEAD && err == nsp_pkg::ST_OK && acc == '0
                             && out_valid))
    else $error("end of string did not clear the parse state");

  a_error_sticks: assert property (@(posedge clk) disable iff (rst)
    (err != nsp_pkg::ST_OK && !(s1_fire && s1_nul)) |=> (err == $past(err)))
    else $error("error code changed before end of string");

endmodule
